// ===== design/flptw_pkg.sv =====
// ----------------------------------------------------------------------------
// Four-level page table walker package
// Payload types, table entry layout and status codes shared by the walker.
// ----------------------------------------------------------------------------
package flptw_pkg;

   localparam int INDEX_BITS        = 9;
   localparam int OFFSET_BITS       = 12;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int ADDR_WIDTH        = 48;
   localparam int TARGET_BITS       = 36;
   localparam int ENTRY_BITS        = 43;
   localparam int LEVEL_BITS        = 2;

   localparam logic KIND_MAP       = 1'b0;
   localparam logic KIND_TRANSLATE = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_ALREADY    = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED  = 2'd2;
   localparam logic [1:0] STATUS_NOT_MAPPED = 2'd3;

   localparam logic [LEVEL_BITS-1:0] LEAF_LEVEL = 2'd3;

   typedef struct packed {
      logic                  kind;
      logic [ADDR_WIDTH-1:0] guest_address;
      logic [ADDR_WIDTH-1:0] host_address;
      logic [2:0]            access_rights;
      logic [2:0]            memory_type;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [ADDR_WIDTH-1:0] translated_address;
   } rsp_payload_type;

   typedef struct packed {
      logic [TARGET_BITS-1:0] target;
      logic [2:0]             memory_type;
      logic [2:0]             rights;
      logic                   present;
   } entry_type;

endpackage

// ===== design/four_level_page_table_walker_unit.sv =====
// ----------------------------------------------------------------------------
// Four-level page table walker
// Maps and translates 48-bit guest addresses through a four-level table held
// in a single-port table page store.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel as one packed payload. A map request
// allocates table pages from a pool at every missing level and writes the
// leaf; a translate request returns the host frame joined with the page
// offset. Each request produces exactly one transfer on the rsp_ channel.
// A walk makes four dependent reads of the table store, each issued in the
// read state and evaluated in the evaluate state, with any new entry written
// during the evaluate state on the same port. A new request is taken only
// after the previous walk has handed its result to the output register, and
// a walk makes fewer reads when a translate finds an empty level early or a
// map runs out of table pages.
// The response sits in an output register; the next request is accepted
// while it waits, and a finished walk holds its result until the register
// frees up when the receiver stalls.
// After reset the store is cleared one entry per cycle, and req_ready stays
// low until that sweep ends. The pool restarts with only the root page in
// use.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit #(
   parameter int TABLE_PAGES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  flptw_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output flptw_pkg::rsp_payload_type rsp_data
);

   localparam int STORE_DEPTH = TABLE_PAGES * flptw_pkg::ENTRIES_PER_TABLE;
   localparam int PAGE_BITS   = $clog2(TABLE_PAGES);
   localparam int SLOT_BITS   = PAGE_BITS + flptw_pkg::INDEX_BITS;
   localparam int CNT_BITS    = $clog2(TABLE_PAGES + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [flptw_pkg::ENTRY_BITS-1:0] table_store_ff [STORE_DEPTH];

   logic [2:0]                          state_ff, state_in;
   logic [SLOT_BITS-1:0]                clr_ff, clr_in;
   logic [flptw_pkg::LEVEL_BITS-1:0]    level_ff, level_in;
   logic [PAGE_BITS-1:0]                page_ff, page_in;
   logic [CNT_BITS-1:0]                 pages_used_ff, pages_used_in;
   flptw_pkg::req_payload_type          req_ff, req_in;
   logic [1:0]                          status_ff, status_in;
   logic [flptw_pkg::ADDR_WIDTH-1:0]    addr_ff, addr_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   flptw_pkg::rsp_payload_type          rsp_data_ff, rsp_data_in;
   logic [flptw_pkg::ENTRY_BITS-1:0]    rd_data_ff;

   flptw_pkg::entry_type                entry;
   flptw_pkg::entry_type                wr_entry;
   logic [flptw_pkg::INDEX_BITS-1:0]    index;
   logic [SLOT_BITS-1:0]                mem_addr;
   logic                                mem_we;
   logic [flptw_pkg::ENTRY_BITS-1:0]    mem_wdata;
   logic                                rsp_free;

   assign entry     = flptw_pkg::entry_type'(rd_data_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (level_ff)
         2'd0:    index = req_ff.guest_address[47:39];
         2'd1:    index = req_ff.guest_address[38:30];
         2'd2:    index = req_ff.guest_address[29:21];
         default: index = req_ff.guest_address[20:12];
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      level_in      = level_ff;
      page_in       = page_ff;
      pages_used_in = pages_used_ff;
      req_in        = req_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      wr_entry      = '0;
      mem_addr      = {page_ff, index};

      case (state_ff)
         S_CLEAR: begin
            mem_addr = clr_ff;
            mem_we   = 1'b1;
            clr_in   = clr_ff + SLOT_BITS'(1);
            if (clr_ff == SLOT_BITS'(STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               level_in  = '0;
               page_in   = '0;
               status_in = flptw_pkg::STATUS_OK;
               addr_in   = '0;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (level_ff != flptw_pkg::LEAF_LEVEL) begin
               if (entry.present &&
                   entry.target < flptw_pkg::TARGET_BITS'(TABLE_PAGES)) begin
                  page_in  = entry.target[PAGE_BITS-1:0];
                  level_in = level_ff + 2'd1;
                  state_in = S_READ;
               end else if (req_ff.kind == flptw_pkg::KIND_TRANSLATE) begin
                  status_in = flptw_pkg::STATUS_NOT_MAPPED;
                  state_in  = S_DONE;
               end else if (pages_used_ff == CNT_BITS'(TABLE_PAGES)) begin
                  status_in = flptw_pkg::STATUS_EXHAUSTED;
                  state_in  = S_DONE;
               end else begin
                  mem_we           = 1'b1;
                  wr_entry.present = 1'b1;
                  wr_entry.rights  = req_ff.access_rights;
                  wr_entry.target  = flptw_pkg::TARGET_BITS'(pages_used_ff);
                  page_in          = pages_used_ff[PAGE_BITS-1:0];
                  pages_used_in    = pages_used_ff + CNT_BITS'(1);
                  level_in         = level_ff + 2'd1;
                  state_in         = S_READ;
               end
            end else begin
               state_in = S_DONE;
               if (req_ff.kind == flptw_pkg::KIND_MAP) begin
                  if (entry.present) begin
                     status_in = flptw_pkg::STATUS_ALREADY;
                  end else begin
                     mem_we               = 1'b1;
                     wr_entry.present     = 1'b1;
                     wr_entry.rights      = req_ff.access_rights;
                     wr_entry.memory_type = req_ff.memory_type;
                     wr_entry.target      = req_ff.host_address[47:12];
                  end
               end else if (!entry.present) begin
                  status_in = flptw_pkg::STATUS_NOT_MAPPED;
               end else begin
                  addr_in = {entry.target, req_ff.guest_address[11:0]};
               end
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.status             = status_ff;
               rsp_data_in.translated_address = addr_ff;
               state_in                       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      mem_wdata = wr_entry;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_store_ff[mem_addr] <= mem_wdata;
      end
      rd_data_ff <= table_store_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         level_ff      <= '0;
         page_ff       <= '0;
         pages_used_ff <= CNT_BITS'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         level_ff      <= level_in;
         page_ff       <= page_in;
         pages_used_ff <= pages_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      status_ff   <= status_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
